// ===== rtl/mtd_pkg.sv =====
`timescale 1ns / 1ps

package mtd_pkg;

   localparam int TIME_W        = 16;
   localparam int PATTERN_W     = 5;
   localparam int COUNT_W       = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int MAX_SYMBOLS_D = 5;

   localparam logic [TIME_W-1:0] DASH_SPLIT_RST = 16'd200;
   localparam logic [TIME_W-1:0] CHAR_GAP_RST   = 16'd600;
   localparam logic [TIME_W-1:0] WORD_GAP_RST   = 16'd1400;
   localparam logic [TIME_W-1:0] IDLE_GAP_RST   = 16'd5000;
   localparam logic [TIME_W-1:0] TIME_MAX       = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DASH_SPLIT = 2'd0,
      CSR_CHAR_GAP   = 2'd1,
      CSR_WORD_GAP   = 2'd2,
      CSR_IDLE_GAP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] dash_split;
      logic [TIME_W-1:0] char_gap;
      logic [TIME_W-1:0] word_gap;
      logic [TIME_W-1:0] idle_gap;
   } csr_type;

   typedef struct packed {
      logic                 char_valid;
      logic [PATTERN_W-1:0] pattern;
      logic [COUNT_W-1:0]   symbol_count;
      logic                 space_valid;
      logic                 idle_flag;
   } result_type;

endpackage

// ===== rtl/mtd_csr.sv =====
`timescale 1ns / 1ps

module mtd_csr
   import mtd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]      csr_data,
   output csr_type                csr
);

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DASH_SPLIT: csr_in.dash_split = csr_data;
            CSR_CHAR_GAP:   csr_in.char_gap   = csr_data;
            CSR_WORD_GAP:   csr_in.word_gap   = csr_data;
            CSR_IDLE_GAP:   csr_in.idle_gap   = csr_data;
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.dash_split <= DASH_SPLIT_RST;
         csr_ff.char_gap   <= CHAR_GAP_RST;
         csr_ff.word_gap   <= WORD_GAP_RST;
         csr_ff.idle_gap   <= IDLE_GAP_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/mtd_core.sv =====
`timescale 1ns / 1ps

module mtd_core
   import mtd_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_D
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       level,
   input  csr_type    csr,
   output result_type result
);

   localparam int TOTAL_W = $clog2(MAX_SYMBOLS + 1);
   localparam int WIDE_W  = (MAX_SYMBOLS > PATTERN_W) ? MAX_SYMBOLS : PATTERN_W;
   localparam int EXT_W   = (TOTAL_W > COUNT_W) ? TOTAL_W : COUNT_W + 1;

   logic                   prev_level_ff, prev_level_in;
   logic [TIME_W-1:0]      elapsed_ff, elapsed_in;
   logic [MAX_SYMBOLS-1:0] symbol_bits_ff, symbol_bits_in;
   logic [TOTAL_W-1:0]     symbol_total_ff, symbol_total_in;
   logic                   pending_space_ff, pending_space_in;

   logic [TIME_W-1:0]      elapsed_inc;
   logic                   is_dash;
   logic [WIDE_W-1:0]      bits_wide;
   logic [EXT_W-1:0]       total_ext;

   assign elapsed_inc = (elapsed_ff != TIME_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign is_dash     = (elapsed_inc >= csr.dash_split);
   assign bits_wide   = WIDE_W'(symbol_bits_ff);
   assign total_ext   = EXT_W'(symbol_total_ff);

   always_comb begin
      elapsed_in       = elapsed_inc;
      symbol_bits_in   = symbol_bits_ff;
      symbol_total_in  = symbol_total_ff;
      pending_space_in = pending_space_ff;
      result           = '0;

      if (level && !prev_level_ff) begin
         elapsed_in = '0;
      end else if (!level && prev_level_ff) begin
         if (symbol_total_ff < TOTAL_W'(MAX_SYMBOLS)) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
               if (is_dash && (symbol_total_ff == TOTAL_W'(i))) begin
                  symbol_bits_in[i] = 1'b1;
               end
            end
            symbol_total_in = symbol_total_ff + 1'b1;
         end
         elapsed_in = '0;
      end

      if (!level) begin
         if ((elapsed_in == csr.char_gap) && (symbol_total_in != '0)) begin
            result.char_valid   = 1'b1;
            result.pattern      = PATTERN_W'(WIDE_W'(symbol_bits_in));
            result.symbol_count = (EXT_W'(symbol_total_in) > EXT_W'(7)) ?
                                  COUNT_W'(7) : COUNT_W'(symbol_total_in);
            symbol_bits_in      = '0;
            symbol_total_in     = '0;
            pending_space_in    = 1'b1;
            elapsed_in          = '0;
         end else if ((elapsed_in == csr.word_gap) && pending_space_ff) begin
            pending_space_in    = 1'b0;
            result.space_valid  = 1'b1;
         end
         result.idle_flag = (elapsed_in == csr.idle_gap);
      end

      prev_level_in = level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff    <= 1'b0;
         elapsed_ff       <= '0;
         symbol_bits_ff   <= '0;
         symbol_total_ff  <= '0;
         pending_space_ff <= 1'b0;
      end else if (step) begin
         prev_level_ff    <= prev_level_in;
         elapsed_ff       <= elapsed_in;
         symbol_bits_ff   <= symbol_bits_in;
         symbol_total_ff  <= symbol_total_in;
         pending_space_ff <= pending_space_in;
      end
   end

   // stored count never exceeds MAX_SYMBOLS, and the pattern holds no symbol beyond the stored count
   assert property (@(posedge clock) disable iff (reset)
      (total_ext <= EXT_W'(MAX_SYMBOLS)))
      else $error("symbol count beyond limit");

   assert property (@(posedge clock) disable iff (reset)
      (symbol_total_ff == '0) |-> (bits_wide == '0))
      else $error("symbol bits set with empty pattern");

   assert property (@(posedge clock) disable iff (reset)
      !(result.char_valid && result.space_valid))
      else $error("character and space on one tick");

endmodule

// ===== rtl/morse_timing_decoder.sv =====
`timescale 1ns / 1ps
// A request passes through the input register, then the result register, before rsp_valid.
// Throughput: one request per cycle while rsp_stall is low; each tick is a single pass through the core logic.
// One result per request. A stalled result holds the core; req_stall rises once the input
// register is also occupied.
// Reset (synchronous, active high) clears both pipeline stages and the decoder state,
// and loads the timing registers with their defaults.
module morse_timing_decoder
   import mtd_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_D
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]      csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_light_on,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_char_valid,
   output logic [PATTERN_W-1:0]   rsp_pattern,
   output logic [COUNT_W-1:0]     rsp_symbol_count,
   output logic                   rsp_space_valid,
   output logic                   rsp_idle_flag
);

   csr_type    csr;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_level_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       out_move;
   logic       in_move;
   logic       step;

   mtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr       (csr)
   );

   mtd_core #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .level  (in_level_ff),
      .csr    (csr),
      .result (result)
   );

   assign out_move     = !rsp_valid_ff || !rsp_stall;
   assign in_move      = !in_valid_ff || out_move;
   assign step         = in_valid_ff && out_move;
   assign req_stall    = !in_move;
   assign in_valid_in  = in_move ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_move ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         in_level_ff <= req_light_on;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_valid   = rsp_ff.char_valid;
   assign rsp_pattern      = rsp_ff.pattern;
   assign rsp_symbol_count = rsp_ff.symbol_count;
   assign rsp_space_valid  = rsp_ff.space_valid;
   assign rsp_idle_flag    = rsp_ff.idle_flag;

   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> (rsp_pattern == '0 && rsp_symbol_count == '0))
      else $error("pattern without character");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_valid) |-> (rsp_symbol_count != '0))
      else $error("empty character emitted");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_move) |=> in_valid_ff)
      else $error("request dropped while output stalled");

endmodule

// ===== test/tb_morse_timing_decoder.sv =====
`timescale 1ns / 1ps

module tb_morse_timing_decoder;
   import mtd_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_TICKS    = 30;

   localparam result_type NONE       = '0;
   localparam result_type FULL_CHAR  = {1'b1, 5'b01010, 3'd5, 1'b0, 1'b0};
   localparam result_type WORD_SPACE = {1'b0, 5'd0, 3'd0, 1'b1, 1'b0};
   localparam result_type IDLE_HIT   = {1'b0, 5'd0, 3'd0, 1'b0, 1'b1};

   typedef struct packed {
      logic       light;
      logic       typed;
      result_type want;
   } tick_row_type;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   csr_write    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = CSR_DASH_SPLIT;
   logic [TIME_W-1:0]      csr_data     = '0;
   logic                   req_valid    = 1'b0;
   logic                   req_light_on = 1'b0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   logic                   rsp_char_valid;
   logic [PATTERN_W-1:0]   rsp_pattern;
   logic [COUNT_W-1:0]     rsp_symbol_count;
   logic                   rsp_space_valid;
   logic                   rsp_idle_flag;

   // decoder model state
   csr_type              timing;
   logic                 lvl_prev;
   logic [TIME_W-1:0]    gap_timer;
   logic [PATTERN_W-1:0] sym_bits;
   int                   sym_total;
   bit                   space_armed;

   result_type tick_results_q[$];

   int err_count    = 0;
   int ticks_sent   = 0;
   int settings_run = 0;
   int chars_seen   = 0;
   int spaces_seen  = 0;
   int idles_seen   = 0;
   int quiet_cycles = 0;
   int send_pct     = 0;
   int stall_pct    = 0;
   int hold_asked   = 0;
   int hold_served  = 0;
   int hold_left    = 0;

   int PACE_SEND [4] = '{0, 63, 0, 9};
   int PACE_STALL[4] = '{0, 0, 63, 9};

   // run under dash 2, char 3, word 4, idle 5
   tick_row_type directed_rows [25] = '{
      {1'b0, 1'b1, NONE},
      {1'b1, 1'b1, NONE},
      {1'b0, 1'b0, NONE},        // dot
      {1'b1, 1'b0, NONE},
      {1'b1, 1'b0, NONE},
      {1'b0, 1'b0, NONE},        // dash
      {1'b1, 1'b0, NONE},
      {1'b0, 1'b0, NONE},
      {1'b1, 1'b0, NONE},
      {1'b1, 1'b0, NONE},
      {1'b0, 1'b0, NONE},
      {1'b1, 1'b0, NONE},
      {1'b0, 1'b0, NONE},        // fifth symbol
      {1'b1, 1'b0, NONE},
      {1'b1, 1'b0, NONE},
      {1'b1, 1'b0, NONE},
      {1'b0, 1'b0, NONE},        // sixth mark dropped, pattern full
      {1'b0, 1'b0, NONE},
      {1'b0, 1'b0, NONE},
      {1'b0, 1'b1, FULL_CHAR},
      {1'b0, 1'b0, NONE},
      {1'b0, 1'b0, NONE},
      {1'b0, 1'b0, NONE},
      {1'b0, 1'b1, WORD_SPACE},
      {1'b0, 1'b1, IDLE_HIT}
   };

   morse_timing_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_light_on     (req_light_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_pattern      (rsp_pattern),
      .rsp_symbol_count (rsp_symbol_count),
      .rsp_space_valid  (rsp_space_valid),
      .rsp_idle_flag    (rsp_idle_flag)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic result_type decode_tick(input logic level);
      logic [TIME_W-1:0] e;
      result_type        r;
      r = NONE;
      e = gap_timer;
      if (e != TIME_MAX) e = e + 1'b1;
      if (level && !lvl_prev) begin
         e = '0;
      end else if (!level && lvl_prev) begin
         if (sym_total < MAX_SYMBOLS_D) begin
            if (e >= timing.dash_split) sym_bits[sym_total] = 1'b1;
            sym_total++;
         end
         e = '0;
      end
      if (!level) begin
         if (e == timing.char_gap && sym_total > 0) begin
            r.char_valid   = 1'b1;
            r.pattern      = sym_bits;
            r.symbol_count = COUNT_W'(sym_total);
            sym_bits       = '0;
            sym_total      = 0;
            space_armed    = 1'b1;
            e              = '0;
         end else if (e == timing.word_gap && space_armed) begin
            space_armed   = 1'b0;
            r.space_valid = 1'b1;
         end
         if (e == timing.idle_gap) r.idle_flag = 1'b1;
      end
      lvl_prev  = level;
      gap_timer = e;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tick_results_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got c=%b p=%b n=%0d s=%b i=%b",
                     $time, rsp_char_valid, rsp_pattern, rsp_symbol_count,
                     rsp_space_valid, rsp_idle_flag);
            err_count++;
         end else begin
            want = tick_results_q.pop_front();
            check_field("char_valid", 8'(want.char_valid), 8'(rsp_char_valid));
            check_field("pattern", 8'(want.pattern), 8'(rsp_pattern));
            check_field("symbol_count", 8'(want.symbol_count), 8'(rsp_symbol_count));
            check_field("space_valid", 8'(want.space_valid), 8'(rsp_space_valid));
            check_field("idle_flag", 8'(want.idle_flag), 8'(rsp_idle_flag));
         end
         if (rsp_char_valid === 1'b1) chars_seen++;
         if (rsp_space_valid === 1'b1) spaces_seen++;
         if (rsp_idle_flag === 1'b1) idles_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, nothing moved for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, tick_results_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_tick(input logic level);
      while (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_light_on <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_results_q.push_back(decode_tick(level));
      ticks_sent++;
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [TIME_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [TIME_W-1:0] dash, input logic [TIME_W-1:0] chr,
                             input logic [TIME_W-1:0] word, input logic [TIME_W-1:0] idle);
      req_valid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_put(CSR_DASH_SPLIT, dash);
      csr_put(CSR_CHAR_GAP, chr);
      csr_put(CSR_WORD_GAP, word);
      csr_put(CSR_IDLE_GAP, idle);
      csr_write         <= 1'b0;
      timing.dash_split = dash;
      timing.char_gap   = chr;
      timing.word_gap   = word;
      timing.idle_gap   = idle;
      settings_run++;
   endtask

   task automatic set_pace(input int snd, input int stl, input bit hold);
      @(negedge clock);
      send_pct  = snd;
      stall_pct = stl;
      if (hold) hold_asked++;
      @(posedge clock);
   endtask

   // mostly well-formed characters with random mark and gap lengths, some noise
   task automatic gen_traffic(input int budget);
      int stop_at;
      int nsym;
      int len;
      int maxg;
      stop_at = ticks_sent + budget;
      maxg    = int'((timing.word_gap > timing.idle_gap) ? timing.word_gap : timing.idle_gap);
      while (ticks_sent < stop_at) begin
         if ($urandom_range(99) < 80) begin
            nsym = $urandom_range(1, MAX_SYMBOLS_D + 2);
            repeat (nsym) begin
               len = $urandom_range(1, 2 * timing.dash_split + 1);
               repeat (len) send_tick(1'b1);
               len = $urandom_range(1, (timing.char_gap > 0) ? timing.char_gap : 1);
               repeat (len) send_tick(1'b0);
            end
            if ($urandom_range(99) < 75) begin
               len = $urandom_range(timing.char_gap + 1, timing.char_gap + maxg + 3);
            end else begin
               len = $urandom_range(1, timing.char_gap + 1);
            end
            repeat (len) send_tick(1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
         end
      end
   endtask

   initial begin : stimulus
      int p;
      timing.dash_split = DASH_SPLIT_RST;
      timing.char_gap   = CHAR_GAP_RST;
      timing.word_gap   = WORD_GAP_RST;
      timing.idle_gap   = IDLE_GAP_RST;
      lvl_prev    = 1'b0;
      gap_timer   = '0;
      sym_bits    = '0;
      sym_total   = 0;
      space_armed = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_timing(16'd2, 16'd3, 16'd4, 16'd5);
      foreach (directed_rows[i]) begin
         send_tick(directed_rows[i].light);
         if (directed_rows[i].typed) begin
            tick_results_q[tick_results_q.size() - 1] = directed_rows[i].want;
         end
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_timing(TIME_W'($urandom_range(1, 3)), TIME_W'($urandom_range(1, 5)),
                    TIME_W'($urandom_range(1, 8)), TIME_W'($urandom_range(1, 10)));
         set_pace(PACE_SEND[p % 4], PACE_STALL[p % 4], p == 4);
         gen_traffic(PHASE_TICKS);
      end

      set_timing(16'd1, 16'd1, 16'd1, 16'd1);
      set_pace(9, 9, 1'b0);
      gen_traffic(30);

      // zero gaps match on the tick the timer restarts
      set_timing(16'd0, 16'd0, 16'd0, 16'd0);
      set_pace(63, 0, 1'b0);
      gen_traffic(30);

      // widest gaps: a short run completes nothing
      set_timing(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
      set_pace(0, 0, 1'b0);
      repeat (3) send_tick(1'b1);
      repeat (20) send_tick(1'b0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);

      req_valid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d light ticks over %0d timing settings (zero, one and max gaps included).",
               ticks_sent, settings_run);
      $display("Decoded %0d characters, %0d word spaces, %0d idle flags.",
               chars_seen, spaces_seen, idles_seen);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mtd_pkg.sv
rtl/mtd_csr.sv
rtl/mtd_core.sv
rtl/morse_timing_decoder.sv
test/tb_morse_timing_decoder.sv
